// ----- src/assert_macros.svh -----
// assertion macros used by the interpolator core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- src/plai_pkg.sv -----
// package for the polyline arc-length interpolator
// types, constants and control structs; no dependencies
package plai_pkg;
   localparam int MaxPointsDefault = 64;
   localparam int CoordBitsDefault = 24;
   localparam int IndexBits = 6;
   localparam int ParamBits = 17;
   localparam int LenBits = 32;
   localparam int MarginBits = 8;
   localparam logic [ParamBits-1:0] OneQ16 = 17'd65536;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      logic op;
      logic [IndexBits-1:0] point_index;
      logic signed [CoordBitsDefault-1:0] point_x;
      logic signed [CoordBitsDefault-1:0] point_y;
      logic signed [CoordBitsDefault-1:0] point_z;
      logic [ParamBits-1:0] query_param;
   } req_type;

   typedef struct packed {
      logic signed [CoordBitsDefault-1:0] pos_x;
      logic signed [CoordBitsDefault-1:0] pos_y;
      logic signed [CoordBitsDefault-1:0] pos_z;
      logic [IndexBits-1:0] segment_found;
      logic [ParamBits-1:0] local_param;
      logic [LenBits-1:0] total_length;
      logic valid_res;
   } rsp_type;

   // shared unit commands
   typedef struct packed {
      logic sqrt_go;
      logic div_go;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
   } unit_cmd_type;

   typedef struct packed {
      logic done;
      logic [63:0] result;
   } unit_sts_type;
endpackage

// ----- src/plai_iter_unit.sv -----
// shared iterative unit: integer square root or unsigned divide, one step a cycle
// depends on plai_pkg
module plai_iter_unit
   import plai_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  unit_cmd_type cmd,
   output unit_sts_type sts
);
   logic        busy_ff, busy_in;
   logic        mode_ff, mode_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;   // sqrt remaining value / div remainder
   logic [63:0] res_ff, res_in;   // sqrt result / div quotient
   logic [63:0] bit_ff, bit_in;   // sqrt bit / div dividend shift
   logic [63:0] den_ff, den_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] shrem;

   always_comb begin
      busy_in = busy_ff;
      mode_in = mode_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      den_in = den_ff;
      done_in = 1'b0;
      trial = '0;
      shrem = '0;
      if (cmd.sqrt_go) begin
         busy_in = 1'b1; mode_in = 1'b0; cnt_in = 7'd32;
         rem_in = cmd.operand_a; res_in = '0; bit_in = 64'd1 << 62;
      end else if (cmd.div_go) begin
         busy_in = 1'b1; mode_in = 1'b1; cnt_in = 7'd64;
         rem_in = '0; res_in = '0; bit_in = cmd.operand_a; den_in = cmd.operand_b;
      end else if (busy_ff) begin
         // one restoring step
         if (!mode_ff) begin
            trial = {1'b0, res_ff} + {1'b0, bit_ff};
            if ({1'b0, rem_ff} >= trial) begin
               rem_in = rem_ff - trial[63:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end else begin
            shrem = {rem_ff, bit_ff[63]};
            bit_in = bit_ff << 1;
            if (shrem >= {1'b0, den_ff}) begin
               rem_in = shrem[63:0] - den_ff;
               res_in = {res_ff[62:0], 1'b1};
            end else begin
               rem_in = shrem[63:0];
               res_in = {res_ff[62:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      mode_ff <= mode_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      den_ff <= den_in;
   end

   assign sts.done = done_ff;
   assign sts.result = res_ff;
endmodule

// ----- src/polyline_arclength_interpolator_core.sv -----
// top level of the polyline arc-length interpolator: sequencer, stores, result register
// depends on plai_pkg, plai_iter_unit and assert_macros.svh
//
// channel | ports                          | handshake
// req     | req_data                       | start high, busy low
// rsp     | rsp_data                       | rsp_strobe, one cycle, no stall
// csr     | csr_write, csr_wdata           | csr_write
// a load reads the previous point, forms the square sum, then runs a 32-step square root in the shared unit
// a query does a linear walk of the length memory,
// a 64-step divide in the shared unit, then 3 axes of interpolation
// synchronous reset clears control and the point count; stores are undefined until written
// results cannot be stalled; busy stays high until the strobe cycle ends
`include "assert_macros.svh"
module polyline_arclength_interpolator_core
   import plai_pkg::*;
#(
   parameter int MAX_POINTS = MaxPointsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  req_type                 req_data,
   output logic                    rsp_strobe,
   output rsp_type                 rsp_data,
   input  logic                    csr_write,
   input  logic [MarginBits-1:0]   csr_wdata
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int CB = CoordBitsDefault;

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_LRD   = 14'b00000000000010,
      ST_LSQ   = 14'b00000000000100,
      ST_LSQRT = 14'b00000000001000,
      ST_LWR   = 14'b00000000010000,
      ST_QTOT  = 14'b00000000100000,
      ST_QMUL  = 14'b00000001000000,
      ST_QRD   = 14'b00000010000000,
      ST_QCMP  = 14'b00000100000000,
      ST_QDIV  = 14'b00001000000000,
      ST_QDWT  = 14'b00010000000000,
      ST_QPRD  = 14'b00100000000000,
      ST_QLERP = 14'b01000000000000,
      ST_DONE  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // memories
   logic [CB-1:0]      mem_x [MAX_POINTS];
   logic [CB-1:0]      mem_y [MAX_POINTS];
   logic [CB-1:0]      mem_z [MAX_POINTS];
   logic [LenBits-1:0] mem_c [MAX_POINTS];
   logic               we;
   logic [AW-1:0]      waddr, raddr;
   logic [CB-1:0]      wx, wy, wz;
   logic [LenBits-1:0] wc;
   logic [CB-1:0]      rx_ff, ry_ff, rz_ff;
   logic [LenBits-1:0] rc_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_x[waddr] <= wx;
         mem_y[waddr] <= wy;
         mem_z[waddr] <= wz;
         mem_c[waddr] <= wc;
      end
      rx_ff <= mem_x[raddr];
      ry_ff <= mem_y[raddr];
      rz_ff <= mem_z[raddr];
      rc_ff <= mem_c[raddr];
   end

   logic [MarginBits-1:0] margin_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [LenBits-1:0]    total_ff, total_in;
   req_type               req_ff;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [1:0]            step_ff, step_in;
   logic [63:0]           acc_ff, acc_in;     // square sum / scaled query
   logic [LenBits-1:0]    clo_ff, clo_in;     // lower cumulative entry
   logic [LenBits-1:0]    chi_ff, chi_in;
   logic [CB-1:0]         p0x_ff, p0y_ff, p0z_ff, p0x_in, p0y_in, p0z_in;
   logic [ParamBits-1:0]  local_ff, local_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  strobe_ff, strobe_in;
   unit_cmd_type          ucmd;
   unit_sts_type          usts;

   plai_iter_unit u_unit (.clock(clock), .reset(reset), .cmd(ucmd), .sts(usts));

   // shared difference and square path
   logic signed [CB:0]   dsub;
   logic [CB:0]          dmag;
   logic [2*CB+1:0]      dsq;
   logic [64:0]          dsum;
   logic [CB-1:0]        sel_new, sel_old;
   logic signed [CB:0]   ldiff;
   logic signed [CB+ParamBits+1:0] lprod;
   logic signed [CB+1:0] lres;
   logic [32:0]          csum;
   logic [ParamBits:0]   mu_lim;

   always_comb begin
      unique case (step_ff)
         2'd0: begin sel_new = req_ff.point_x; sel_old = rx_ff; end
         2'd1: begin sel_new = req_ff.point_y; sel_old = ry_ff; end
         default: begin sel_new = req_ff.point_z; sel_old = rz_ff; end
      endcase
      dsub = $signed({sel_new[CB-1], sel_new}) - $signed({sel_old[CB-1], sel_old});
      dmag = dsub[CB] ? (~dsub + 1'b1) : dsub;
      dsq = {{(CB+1){1'b0}}, dmag} * {{(CB+1){1'b0}}, dmag};
      dsum = {1'b0, acc_ff} + {{(64-2*CB-1){1'b0}}, dsq};
      // interpolation: p1 from the read port, p0 from holding regs
      unique case (step_ff)
         2'd0: ldiff = $signed({rx_ff[CB-1], rx_ff}) - $signed({p0x_ff[CB-1], p0x_ff});
         2'd1: ldiff = $signed({ry_ff[CB-1], ry_ff}) - $signed({p0y_ff[CB-1], p0y_ff});
         default: ldiff = $signed({rz_ff[CB-1], rz_ff}) - $signed({p0z_ff[CB-1], p0z_ff});
      endcase
      lprod = ldiff * $signed({1'b0, local_ff});
      csum = {1'b0, clo_ff} + {1'b0, usts.result[31:0]};
      mu_lim = {1'b0, OneQ16} - {{(ParamBits+1-MarginBits){1'b0}}, margin_ff};
   end

   always_comb begin
      lres = '0;
      unique case (step_ff)
         2'd0: lres = $signed({p0x_ff[CB-1], p0x_ff[CB-1], p0x_ff});
         2'd1: lres = $signed({p0y_ff[CB-1], p0y_ff[CB-1], p0y_ff});
         default: lres = $signed({p0z_ff[CB-1], p0z_ff[CB-1], p0z_ff});
      endcase
      lres = lres + lprod[CB+ParamBits:16];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      total_in = total_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      clo_in = clo_ff;
      chi_in = chi_ff;
      p0x_in = p0x_ff; p0y_in = p0y_ff; p0z_in = p0z_ff;
      local_in = local_ff;
      rsp_in = rsp_ff;
      strobe_in = 1'b0;
      we = 1'b0;
      waddr = count_ff[AW-1:0];
      wx = req_ff.point_x; wy = req_ff.point_y; wz = req_ff.point_z;
      wc = '0;
      raddr = idx_ff;
      ucmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !strobe_ff) begin
               rsp_in = '0;
               step_in = 2'd0;
               acc_in = '0;
               if (req_data.op == OP_LOAD) begin
                  if (req_data.point_index == '0) count_in = '0;
                  state_in = ST_LRD;
               end else begin
                  state_in = ST_QTOT;
               end
            end
         end
         ST_LRD: begin
            // fetch the previous point
            raddr = AW'(count_ff - 1'b1);
            if (count_ff == CW'(MAX_POINTS)) state_in = ST_DONE;
            else if (count_ff == '0) begin
               we = 1'b1; wc = '0; total_in = '0;
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end else state_in = ST_LSQ;
         end
         ST_LSQ: begin
            // keep the previous point on the read port
            raddr = AW'(count_ff - 1'b1);
            acc_in = dsum[64] ? '1 : dsum[63:0];
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) state_in = ST_LSQRT;
         end
         ST_LSQRT: begin
            ucmd.sqrt_go = 1'b1;
            ucmd.operand_a = acc_ff;
            clo_in = total_ff;
            state_in = ST_LWR;
         end
         ST_LWR: begin
            if (usts.done) begin
               we = 1'b1;
               wc = (csum[32] || usts.result[63:32] != '0) ? '1 : csum[31:0];
               total_in = wc;
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_QTOT: begin
            if (count_ff < CW'(2)) state_in = ST_DONE;
            else begin
               rsp_in.valid_res = 1'b1;
               if ({1'b0, req_ff.query_param} <= {{(ParamBits+1-MarginBits){1'b0}}, margin_ff}) begin
                  idx_in = '0; state_in = ST_QPRD;
                  local_in = '0; rsp_in.segment_found = '0;
                  acc_in = '1; // marks snap
               end else if ({1'b0, req_ff.query_param} >= mu_lim) begin
                  idx_in = AW'(count_ff - 1'b1); state_in = ST_QPRD;
                  local_in = OneQ16;
                  rsp_in.segment_found = IndexBits'(count_ff - CW'(2));
                  acc_in = '1;
               end else begin
                  state_in = ST_QMUL;
               end
            end
         end
         ST_QMUL: begin
            acc_in = {15'd0, req_ff.query_param} * {32'd0, total_ff};
            idx_in = AW'(1);
            clo_in = '0;
            state_in = ST_QRD;
         end
         ST_QRD: begin
            state_in = ST_QCMP;
         end
         ST_QCMP: begin
            // walk the cumulative table
            if (({16'd0, rc_ff} << 16) < acc_ff && {1'b0, idx_ff} < CW'(count_ff - 1'b1)) begin
               clo_in = rc_ff;
               idx_in = idx_ff + 1'b1;
               state_in = ST_QRD;
            end else begin
               chi_in = rc_ff;
               state_in = ST_QDIV;
            end
         end
         ST_QDIV: begin
            if (chi_ff == clo_ff || acc_ff <= ({16'd0, clo_ff} << 16)) begin
               local_in = '0;
               state_in = ST_QPRD;
               idx_in = idx_ff - 1'b1;
            end else begin
               ucmd.div_go = 1'b1;
               ucmd.operand_a = acc_ff - ({16'd0, clo_ff} << 16);
               ucmd.operand_b = {32'd0, chi_ff - clo_ff};
               state_in = ST_QDWT;
            end
         end
         ST_QDWT: begin
            if (usts.done) begin
               local_in = (usts.result > 64'd65536) ? OneQ16 : usts.result[ParamBits-1:0];
               idx_in = idx_ff - 1'b1;
               state_in = ST_QPRD;
            end
         end
         ST_QPRD: begin
            // idx_ff = lower point; read it, then the upper
            if (step_ff == 2'd0) begin
               rsp_in.segment_found = (acc_ff == '1) ? rsp_ff.segment_found
                                                      : IndexBits'(idx_ff);
               step_in = 2'd1;
            end else if (step_ff == 2'd1) begin
               p0x_in = rx_ff; p0y_in = ry_ff; p0z_in = rz_ff;
               if (acc_ff == '1) begin
                  rsp_in.pos_x = rx_ff; rsp_in.pos_y = ry_ff; rsp_in.pos_z = rz_ff;
                  rsp_in.local_param = local_ff;
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  step_in = 2'd2;
               end
            end else if (step_ff == 2'd2) begin
               step_in = 2'd3;
            end else begin
               step_in = 2'd0;
               rsp_in.local_param = local_ff;
               state_in = ST_QLERP;
            end
         end
         ST_QLERP: begin
            unique case (step_ff)
               2'd0: rsp_in.pos_x = lres[CB-1:0];
               2'd1: rsp_in.pos_y = lres[CB-1:0];
               default: rsp_in.pos_z = lres[CB-1:0];
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_in.total_length = total_ff;
            strobe_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         margin_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         strobe_ff <= strobe_in;
         if (csr_write) margin_ff <= csr_wdata;
      end
      if (start && !busy) req_ff <= req_data;
      idx_ff <= idx_in;
      step_ff <= step_in;
      acc_ff <= acc_in;
      clo_ff <= clo_in;
      chi_ff <= chi_in;
      p0x_ff <= p0x_in; p0y_ff <= p0y_in; p0z_ff <= p0z_in;
      local_ff <= local_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE) || strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_IMPL(a_onehot, clock, reset, $onehot(state_ff))
   `ASSERT_IMPL(a_strobe_after_done, clock, reset, (state_ff == ST_DONE) |=> rsp_strobe)
   `ASSERT_IMPL(a_count_range, clock, reset, count_ff <= CW'(MAX_POINTS))
   `ASSERT_IMPL(a_valid_needs_points, clock, reset, rsp_strobe && rsp_data.valid_res |-> count_ff >= CW'(2))
endmodule
